// ===== hw/rtl/stkc_pkg.sv =====
// ----------------------------------------------------------------------------
// stkc_pkg
// Shared constants, codes and helper types for the stack calculator.
// ----------------------------------------------------------------------------
package stkc_pkg;

  localparam int unsigned DefaultDepth = 1024;
  localparam int unsigned DataW = 32;
  localparam int unsigned OpW = 3;
  localparam int unsigned IndexW = 10;
  localparam int unsigned StatusW = 3;
  localparam int unsigned DepthW = 11;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 3'd0,
    OP_POP = 3'd1,
    OP_RD_TOP = 3'd2,
    OP_RD_BOT = 3'd3,
    OP_ADD = 3'd4,
    OP_SUB = 3'd5,
    OP_MUL = 3'd6,
    OP_DIV = 3'd7
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK = 3'd0,
    ST_FULL = 3'd1,
    ST_EMPTY = 3'd2,
    ST_INDEX = 3'd3,
    ST_FEW = 3'd4,
    ST_DIVZERO = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_T,
    S_READ_S,
    S_EXEC,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic [DataW-1:0] num;
    logic [DataW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DataW-1:0] quot;
  } div_rsp_t;

endpackage

// ===== hw/rtl/stkc_div.sv =====
// ----------------------------------------------------------------------------
// stkc_div
// Iterative signed floor divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stkc_div (
  input  logic clk,
  input  logic rst,
  input  stkc_pkg::div_req_t req,
  output stkc_pkg::div_rsp_t rsp
);
  import stkc_pkg::*;

  logic busy;
  logic [5:0] count;
  logic [DataW-1:0] quo;
  logic [DataW:0] rem;
  logic [DataW-1:0] dmag;
  logic neg_q;
  logic neg_r;
  logic done;

  logic [DataW:0] trial;
  logic [DataW:0] shifted;
  logic [DataW-1:0] q_next;
  logic [DataW:0] rem_next;
  logic [DataW-1:0] nmag;
  logic [DataW-1:0] q_signed;

  assign nmag = req.num[DataW-1] ? (~req.num + 1'b1) : req.num;
  assign shifted = {rem[DataW-1:0], quo[DataW-1]};
  assign trial = shifted - {1'b0, dmag};
  assign q_next = {quo[DataW-2:0], ~trial[DataW]};
  assign rem_next = trial[DataW] ? shifted : trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 6'(DataW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= nmag;
      rem <= '0;
      dmag <= req.den[DataW-1] ? (~req.den + 1'b1) : req.den;
      neg_q <= req.num[DataW-1] ^ req.den[DataW-1];
    end else if (busy) begin
      quo <= q_next;
      rem <= rem_next;
    end
  end

  assign neg_r = (rem != '0);
  assign q_signed = neg_q ? (~quo + 1'b1) - DataW'(neg_r) : quo;
  assign rsp.done = done;
  assign rsp.quot = q_signed;

endmodule

// ===== hw/rtl/stkc_ctrl.sv =====
// ----------------------------------------------------------------------------
// stkc_ctrl
// Command sequencer: owns the stack memory and the entry count.
// ----------------------------------------------------------------------------
module stkc_ctrl #(
  parameter int unsigned STACK_DEPTH = stkc_pkg::DefaultDepth,
  parameter int unsigned AddrW = $clog2(STACK_DEPTH)
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [stkc_pkg::OpW-1:0] opcode,
  input  logic signed [stkc_pkg::DataW-1:0] operand_value,
  input  logic [stkc_pkg::IndexW-1:0] entry_index,
  output logic busy,
  output logic done,
  output logic signed [stkc_pkg::DataW-1:0] result_value,
  output logic [stkc_pkg::StatusW-1:0] status,
  output logic [stkc_pkg::DepthW-1:0] depth,
  output stkc_pkg::div_req_t div_req,
  input  stkc_pkg::div_rsp_t div_rsp
);
  import stkc_pkg::*;

  localparam int unsigned CntW = AddrW + 1;

  logic [DataW-1:0] mem [STACK_DEPTH];
  logic [DataW-1:0] rd_data;
  logic [AddrW-1:0] rd_addr;
  logic rd_en;
  logic [AddrW-1:0] wr_addr;
  logic [DataW-1:0] wr_data;
  logic wr_en;

  state_t state, state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] count_next;
  op_t op;
  logic [DataW-1:0] val;
  logic [IndexW-1:0] idx;
  logic [DataW-1:0] top;
  logic [DataW-1:0] res;
  logic [DataW-1:0] res_next;
  status_t st;
  status_t st_next;
  logic [DataW-1:0] prod;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  logic need_mem;
  logic bad;
  status_t bad_st;

  always_comb begin
    bad = 1'b0;
    bad_st = ST_OK;
    case (op)
      OP_PUSH: begin
        bad = (count == CntW'(STACK_DEPTH));
        bad_st = ST_FULL;
      end
      OP_POP: begin
        bad = (count == '0);
        bad_st = ST_EMPTY;
      end
      OP_RD_TOP, OP_RD_BOT: begin
        bad = (32'(idx) >= 32'(count));
        bad_st = ST_INDEX;
      end
      default: begin
        bad = (count < CntW'(2));
        bad_st = ST_FEW;
      end
    endcase
  end

  assign need_mem = !bad && (op != OP_PUSH);

  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    if (state == S_READ_T) begin
      rd_en = 1'b1;
      case (op)
        OP_RD_TOP: rd_addr = AddrW'(count - CntW'(idx) - 1'b1);
        OP_RD_BOT: rd_addr = AddrW'(idx);
        default:   rd_addr = AddrW'(count - 1'b1);
      endcase
    end else if (state == S_READ_S) begin
      rd_en = 1'b1;
      rd_addr = AddrW'(count - CntW'(2));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_READ_T;
      S_READ_T: begin
        if (!need_mem) state_next = S_DONE;
        else if (op == OP_POP || op == OP_RD_TOP || op == OP_RD_BOT) state_next = S_EXEC;
        else state_next = S_READ_S;
      end
      S_READ_S: state_next = S_EXEC;
      S_EXEC: begin
        if (op == OP_DIV && top != '0) state_next = S_DIV;
        else state_next = S_DONE;
      end
      S_DIV:    if (div_rsp.done) state_next = S_DONE;
      S_DONE:   state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign prod = top * rd_data;

  always_comb begin
    res_next = res;
    st_next = st;
    count_next = count;
    wr_en = 1'b0;
    wr_addr = AddrW'(count);
    wr_data = val;
    div_req = '0;
    div_req.num = rd_data;
    div_req.den = top;
    case (state)
      S_READ_T: begin
        res_next = '0;
        st_next = bad ? bad_st : ST_OK;
        if (!bad && op == OP_PUSH) begin
          wr_en = 1'b1;
          count_next = count + 1'b1;
        end
      end
      S_EXEC: begin
        case (op)
          OP_POP: begin
            res_next = rd_data;
            count_next = count - 1'b1;
          end
          OP_RD_TOP, OP_RD_BOT: res_next = rd_data;
          OP_ADD, OP_SUB, OP_MUL: begin
            res_next = (op == OP_ADD) ? top + rd_data :
                       (op == OP_SUB) ? rd_data - top : prod;
            wr_en = 1'b1;
            wr_addr = AddrW'(count - CntW'(2));
            wr_data = res_next;
            count_next = count - 1'b1;
          end
          default: begin
            if (top == '0) begin
              st_next = ST_DIVZERO;
              count_next = count - CntW'(2);
            end else begin
              div_req.start = 1'b1;
            end
          end
        endcase
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res_next = div_rsp.quot;
          wr_en = 1'b1;
          wr_addr = AddrW'(count - CntW'(2));
          wr_data = div_rsp.quot;
          count_next = count - 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    st <= st_next;
    if (state == S_IDLE && start) begin
      op <= op_t'(opcode);
      val <= operand_value;
      idx <= entry_index;
    end
    if (state == S_READ_S) begin
      top <= rd_data;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);
  assign result_value = res;
  assign status = st;
  assign depth = DepthW'(count);

endmodule

// ===== hw/rtl/stack_calculator.sv =====
// ----------------------------------------------------------------------------
// stack_calculator
// Bounded stack of 32-bit integers with calculator commands.
// ----------------------------------------------------------------------------
// A command (opcode, operand_value, entry_index) is taken when start is high
// and busy is low. Exactly one result comes back on result_value, status and
// depth, marked by done for one cycle; the receiver cannot stall it.
// Rejected commands and push finish without waiting on a memory read; pop and
// reads wait on one read of the stack memory, add, sub and mul on two, one per
// operand. Divide with a nonzero divisor also waits on the divider, which makes
// one quotient bit per cycle. busy stays high until the result cycle ends, so
// the next command can be taken in the cycle after done.
// Reset empties the stack at once; entry contents are undefined until pushed.
// ----------------------------------------------------------------------------
module stack_calculator #(
  parameter int unsigned STACK_DEPTH = stkc_pkg::DefaultDepth
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [stkc_pkg::OpW-1:0] opcode,
  input  logic signed [stkc_pkg::DataW-1:0] operand_value,
  input  logic [stkc_pkg::IndexW-1:0] entry_index,
  output logic busy,
  output logic done,
  output logic signed [stkc_pkg::DataW-1:0] result_value,
  output logic [stkc_pkg::StatusW-1:0] status,
  output logic [stkc_pkg::DepthW-1:0] depth
);
  import stkc_pkg::*;

  div_req_t div_req;
  div_rsp_t div_rsp;

  stkc_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
    .clk, .rst, .start, .opcode, .operand_value, .entry_index,
    .busy, .done, .result_value, .status, .depth,
    .div_req, .div_rsp
  );

  stkc_div u_div (.clk, .rst, .req(div_req), .rsp(div_rsp));

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done longer than one cycle");
  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    32'(depth) <= STACK_DEPTH) else $error("depth overflow");
`endif

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the stack calculator. Requests are driven from
// a queue with random gaps; every result is compared with a behavioral model
// of the stack that is updated as each request is accepted.
// ----------------------------------------------------------------------------
module tb;
  import stkc_pkg::*;

  typedef struct {
    op_t op;
    logic signed [DataW-1:0] value;
    logic [IndexW-1:0] index;
  } request_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    status_t status;
    logic [DepthW-1:0] depth;
  } answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [OpW-1:0] opcode = '0;
  logic signed [DataW-1:0] operand_value = '0;
  logic [IndexW-1:0] entry_index = '0;
  logic busy;
  logic done;
  logic signed [DataW-1:0] result_value;
  logic [StatusW-1:0] status;
  logic [DepthW-1:0] depth;

  request_t pending_requests[$];
  answer_t expected_answers[$];
  logic [DataW-1:0] model_stack[DefaultDepth];
  int unsigned model_count = 0;
  int errors = 0;
  int gap = 0;
  bit feeding_done = 1'b0;
  bit drain_hold = 1'b0;

  stack_calculator i_dut (
    .clk(clk), .rst(rst), .start(start), .opcode(opcode),
    .operand_value(operand_value), .entry_index(entry_index), .busy(busy),
    .done(done), .result_value(result_value), .status(status), .depth(depth)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [DataW-1:0] floor_quotient(logic [DataW-1:0] num,
                                                      logic [DataW-1:0] den);
    longint a;
    longint b;
    longint q;
    a = longint'($signed(num));
    b = longint'($signed(den));
    q = a / b;
    if ((a % b != 0) && ((a < 0) != (b < 0))) q = q - 1;
    return q[DataW-1:0];
  endfunction

  function automatic answer_t stack_step(request_t rq);
    answer_t a;
    logic [DataW-1:0] t;
    logic [DataW-1:0] s;
    logic [DataW-1:0] r;
    a.value = '0;
    a.status = ST_OK;
    case (rq.op)
      OP_PUSH: begin
        if (model_count >= DefaultDepth) a.status = ST_FULL;
        else begin
          model_stack[model_count] = rq.value;
          model_count++;
        end
      end
      OP_POP: begin
        if (model_count == 0) a.status = ST_EMPTY;
        else begin
          model_count--;
          a.value = model_stack[model_count];
        end
      end
      OP_RD_TOP, OP_RD_BOT: begin
        if (rq.index >= model_count) a.status = ST_INDEX;
        else if (rq.op == OP_RD_TOP) a.value = model_stack[model_count - rq.index - 1];
        else a.value = model_stack[rq.index];
      end
      default: begin
        if (model_count < 2) a.status = ST_FEW;
        else begin
          t = model_stack[model_count - 1];
          s = model_stack[model_count - 2];
          model_count -= 2;
          case (rq.op)
            OP_ADD: r = s + t;
            OP_SUB: r = s - t;
            OP_MUL: r = s * t;
            default: r = (t == 0) ? '0 : floor_quotient(s, t);
          endcase
          if (rq.op == OP_DIV && t == 0) a.status = ST_DIVZERO;
          else begin
            model_stack[model_count] = r;
            model_count++;
            a.value = r;
          end
        end
      end
    endcase
    a.depth = model_count[DepthW-1:0];
    return a;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch in %s: got %0d, expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int random_gap();
    if ($urandom_range(0, 3) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    return $urandom_range(0, 3);
  endfunction

  // The model is updated at acceptance, so the stack that it tracks
  // mirrors the depth the block will reach.
  always @(posedge clk) begin
    if (start && !busy && !rst) begin
      request_t rq;
      rq.op = op_t'(opcode);
      rq.value = operand_value;
      rq.index = entry_index;
      expected_answers.push_back(stack_step(rq));
    end
    if (rst) begin
      start <= 1'b0;
    end else if (start && !busy) begin
      start <= 1'b0;
      gap = random_gap();
    end else if (!start) begin
      if (gap > 0) gap--;
      else if (pending_requests.size() > 0 && !drain_hold) begin
        request_t rq;
        rq = pending_requests.pop_front();
        start <= 1'b1;
        opcode <= rq.op;
        operand_value <= rq.value;
        entry_index <= rq.index;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_answers.size() == 0) begin
        $display("unexpected result at %0t", $time);
        errors++;
      end else begin
        answer_t a;
        a = expected_answers.pop_front();
        if (result_value !== a.value) report_mismatch("result_value", result_value, a.value);
        if (status !== a.status) report_mismatch("status", status, a.status);
        if (depth !== a.depth) report_mismatch("depth", depth, a.depth);
      end
    end
  end

  // The generator tracks its own depth so that reads never touch unwritten
  // entries and every special case is reachable.
  int unsigned gen_depth = 0;

  function automatic logic [DataW-1:0] random_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // Divide by zero cannot be known ahead without the values; the generator
  // keeps its own copy of the values for that reason.
  logic [DataW-1:0] gen_stack[DefaultDepth];

  task automatic gen(op_t op, logic [DataW-1:0] v, logic [IndexW-1:0] ix);
    logic [DataW-1:0] t;
    logic [DataW-1:0] s;
    request_t rq;
    rq.op = op;
    rq.value = v;
    rq.index = ix;
    pending_requests.push_back(rq);
    case (op)
      OP_PUSH: if (gen_depth < DefaultDepth) begin
        gen_stack[gen_depth] = v;
        gen_depth++;
      end
      OP_POP: if (gen_depth > 0) gen_depth--;
      OP_RD_TOP, OP_RD_BOT: ;
      default: if (gen_depth >= 2) begin
        t = gen_stack[gen_depth - 1];
        s = gen_stack[gen_depth - 2];
        gen_depth -= 2;
        if (!(op == OP_DIV && t == 0)) begin
          case (op)
            OP_ADD: gen_stack[gen_depth] = s + t;
            OP_SUB: gen_stack[gen_depth] = s - t;
            OP_MUL: gen_stack[gen_depth] = s * t;
            default: gen_stack[gen_depth] = floor_quotient(s, t);
          endcase
          gen_depth++;
        end
      end
    endcase
  endtask

  task automatic gen_random();
    int k;
    logic [IndexW-1:0] ix;
    k = $urandom_range(0, 99);
    if (gen_depth > 0 && $urandom_range(0, 3) != 0) begin
      ix = IndexW'($urandom_range(0, gen_depth - 1));
    end else begin
      ix = IndexW'($urandom);
    end
    if (k < 35) gen(OP_PUSH, random_value(), ix);
    else if (k < 45) gen(OP_POP, random_value(), ix);
    else if (k < 55) gen(OP_RD_TOP, random_value(), ix);
    else if (k < 65) gen(OP_RD_BOT, random_value(), ix);
    else gen(op_t'($urandom_range(OP_ADD, OP_DIV)), random_value(), ix);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // Empty and too-few cases, then basic arithmetic and division edges.
    gen(OP_POP, 32'h0, 10'd0);
    gen(OP_RD_TOP, 32'h0, 10'd0);
    gen(OP_RD_BOT, 32'h0, 10'h3ff);
    gen(OP_ADD, 32'h0, 10'd0);
    gen(OP_PUSH, 32'h8000_0000, 10'h3ff);
    gen(OP_DIV, 32'h0, 10'd0);
    gen(OP_PUSH, 32'hffff_ffff, 10'd0);
    gen(OP_DIV, 32'h0, 10'd0);
    gen(OP_PUSH, 32'h7fff_ffff, 10'd0);
    gen(OP_PUSH, 32'h7fff_ffff, 10'd0);
    gen(OP_ADD, 32'h0, 10'd0);
    gen(OP_PUSH, 32'h0, 10'd0);
    gen(OP_DIV, 32'h0, 10'd0);
    gen(OP_PUSH, -32'sd7, 10'd0);
    gen(OP_PUSH, 32'sd2, 10'd0);
    gen(OP_DIV, 32'h0, 10'd0);
    gen(OP_RD_TOP, 32'h0, 10'd0);
    gen(OP_RD_BOT, 32'h0, 10'd1);
    gen(OP_RD_TOP, 32'h0, 10'd2);
    gen(OP_PUSH, 32'sd3, 10'd0);
    gen(OP_SUB, 32'h0, 10'd0);
    gen(OP_PUSH, 32'h8000_0001, 10'd0);
    gen(OP_MUL, 32'h0, 10'd0);
    for (int i = 0; i < 150; i++) gen_random();
    // Hold off until the block has drained, then fill the stack to the top.
    wait (pending_requests.size() == 0);
    drain_hold = 1'b1;
    @(posedge clk);
    wait (expected_answers.size() == 0 && !busy && !start);
    drain_hold = 1'b0;
    while (gen_depth < DefaultDepth) gen(OP_PUSH, $urandom, IndexW'($urandom));
    gen(OP_PUSH, 32'h1234_5678, 10'd0);
    gen(OP_RD_TOP, 32'h0, 10'h3ff);
    gen(OP_RD_BOT, 32'h0, 10'h3ff);
    for (int i = 0; i < 50; i++) gen_random();
    feeding_done = 1'b1;
  end

  initial begin
    wait (feeding_done && pending_requests.size() == 0);
    @(posedge clk);
    wait (expected_answers.size() == 0 && !start && !busy);
    repeat (60) @(posedge clk);
    if (errors == 0 && expected_answers.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/stkc_pkg.sv
hw/rtl/stkc_div.sv
hw/rtl/stkc_ctrl.sv
hw/rtl/stack_calculator.sv
test/tb.sv
